// File: rtl/imh_pkg.sv
// Shared types and constants for the indexed min-heap.
package imh_pkg;

    localparam int KEY_BITS = 32;
    localparam int NODE_W   = 8;
    localparam int CNT_W    = 9;
    // Stored ids span every count that init can load (node_count is 9 bits).
    localparam int ID_W     = CNT_W;

    typedef enum logic [1:0] {
        CMD_INIT     = 2'd0,
        CMD_DECREASE = 2'd1,
        CMD_POP      = 2'd2,
        CMD_DELETE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_MISSING = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [NODE_W-1:0]   node_id;
        logic [KEY_BITS-1:0] new_key;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] popped_id;
        status_t           status;
        logic [CNT_W-1:0]  remaining;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_RD,
        ST_POP_ID,
        ST_POP_LAST,
        ST_POP_LOAD,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP
    } state_t;

endpackage

// File: rtl/indexed_min_heap.sv
// Indexed binary min-heap with init, decrease-key, pop-minimum and delete commands.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  command  | start in, busy out     | req (cmd, node_id, new_key)
//  result   | done out, one cycle    | result (popped_id, status, remaining)
//  config   | cfg_valid / cfg_ready  | cfg_data (node_count)
//
// One command at a time; busy stays high until its result is on the port.
// Every heap access goes through one RAM port pair, one entry per cycle.
// Init writes one entry per slot up to node_count; decrease and delete first scan
// the entries for the id and sift up level by level; pop and delete sift down
// level by level. Reset empties the heap and sets node_count to 256.
// The result beat lasts one cycle and cannot be held off.
module indexed_min_heap #(
    parameter int MAX_NODES = 256
) (
    clk,
    rst_n,
    start,
    busy,
    req,
    done,
    result,
    cfg_valid,
    cfg_ready,
    cfg_data
);
    import imh_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int XW = (AW + 2 > CNT_W + 1) ? AW + 2 : CNT_W + 1;

    input  logic                   clk;
    input  logic                   rst_n;
    input  logic                   start;
    output logic                   busy;
    input  imh_pkg::req_t          req;
    output logic                   done;
    output imh_pkg::result_t       result;
    input  logic                   cfg_valid;
    output logic                   cfg_ready;
    input  logic [imh_pkg::CNT_W-1:0] cfg_data;

    state_t              state_reg, state_next;
    cmd_t                op_reg, op_next;
    logic [NODE_W-1:0]   tid_reg, tid_next;
    logic [KEY_BITS-1:0] nkey_reg, nkey_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    node_count_reg;
    logic [XW-1:0]       idx_reg, idx_next;
    logic [XW-1:0]       pos_reg, pos_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [XW-1:0]       chk_addr_reg, chk_addr_next;
    entry_t              cur_reg, cur_next;
    entry_t              best_reg, best_next;
    logic [XW-1:0]       best_idx_reg, best_idx_next;
    logic                moved_reg, moved_next;
    logic [NODE_W-1:0]   popped_reg, popped_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;

    logic          ram_we;
    logic [XW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [XW-1:0] ram_raddr;
    entry_t        rd_entry;

    logic [CNT_W-1:0] init_n;
    logic [XW-1:0]    count_x;
    logic [XW-1:0]    init_x;
    logic [XW-1:0]    l_idx;
    logic [XW-1:0]    r_idx;
    logic [XW-1:0]    parent_idx;
    logic             finish;
    status_t          fin_status;

    imh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr[AW-1:0]),
        .rdata (rd_entry)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        if (int'(node_count_reg) > MAX_NODES)
        begin
            init_n = CNT_W'(MAX_NODES);
        end
        else
        begin
            init_n = node_count_reg;
        end
    end

    assign count_x    = {{(XW-CNT_W){1'b0}}, count_reg};
    assign init_x     = {{(XW-CNT_W){1'b0}}, init_n};
    assign l_idx      = {pos_reg[XW-2:0], 1'b1};
    assign r_idx      = l_idx + XW'(1);
    assign parent_idx = (pos_reg - XW'(1)) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            node_count_reg <= CNT_W'(256);
            chk_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tid_reg      <= tid_next;
        nkey_reg     <= nkey_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        chk_addr_reg <= chk_addr_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        moved_reg    <= moved_next;
        popped_reg   <= popped_next;
        result_reg   <= result_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        nkey_next      = nkey_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        moved_next     = moved_reg;
        popped_next    = popped_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        finish         = 1'b0;
        fin_status     = STAT_OK;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = cur_reg;
        ram_raddr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = req.cmd;
                    tid_next       = req.node_id;
                    nkey_next      = req.new_key;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                    popped_next    = '0;
                    case (req.cmd)
                        CMD_INIT:
                        begin
                            state_next = ST_INIT;
                        end
                        CMD_DECREASE:
                        begin
                            state_next = ST_SCAN;
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                finish     = 1'b1;
                                fin_status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_POP_RD;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                finish     = 1'b1;
                                fin_status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_INIT:
            begin
                if (idx_reg < init_x)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = idx_reg;
                    ram_wdata.id  = idx_reg[ID_W-1:0];
                    ram_wdata.key = '1;
                    idx_next      = idx_reg + XW'(1);
                end
                else
                begin
                    count_next = init_n;
                    finish     = 1'b1;
                end
            end

            // Reads stream one entry a cycle; each compare happens in the cycle after its read.
            ST_SCAN:
            begin
                if (chk_valid_reg &&
                    rd_entry.id == {{(ID_W-NODE_W){1'b0}}, tid_reg})
                begin
                    pos_next       = chk_addr_reg;
                    chk_valid_next = 1'b0;
                    if (op_reg == CMD_DECREASE)
                    begin
                        if (nkey_reg < rd_entry.key)
                        begin
                            cur_next.id  = rd_entry.id;
                            cur_next.key = nkey_reg;
                            state_next   = ST_UP_RD;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_next   = rd_entry;
                        state_next = ST_UP_RD;
                    end
                end
                else if (idx_reg < count_x)
                begin
                    ram_raddr      = idx_reg;
                    chk_addr_next  = idx_reg;
                    chk_valid_next = 1'b1;
                    idx_next       = idx_reg + XW'(1);
                end
                else if (chk_valid_reg)
                begin
                    chk_valid_next = 1'b0;
                end
                else
                begin
                    finish     = 1'b1;
                    fin_status = STAT_MISSING;
                end
            end

            // Hole-based sift-up: parents move down, the entry is written once at the end (never for delete).
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    if (op_reg == CMD_DELETE)
                    begin
                        popped_next = cur_reg.id[NODE_W-1:0];
                        state_next  = ST_POP_LAST;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        finish = 1'b1;
                    end
                end
                else
                begin
                    ram_raddr  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (op_reg == CMD_DELETE || rd_entry.key > cur_reg.key)
                begin
                    ram_wdata  = rd_entry;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            ST_POP_RD:
            begin
                ram_raddr  = '0;
                state_next = ST_POP_ID;
            end

            ST_POP_ID:
            begin
                popped_next = rd_entry.id[NODE_W-1:0];
                state_next  = ST_POP_LAST;
            end

            ST_POP_LAST:
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    finish = 1'b1;
                end
                else
                begin
                    ram_raddr  = count_x - XW'(1);
                    state_next = ST_POP_LOAD;
                end
            end

            ST_POP_LOAD:
            begin
                cur_next   = rd_entry;
                pos_next   = '0;
                state_next = ST_DN_RDL;
            end

            ST_DN_RDL:
            begin
                if (l_idx < count_x)
                begin
                    ram_raddr  = l_idx;
                    state_next = ST_DN_RDR;
                end
                else
                begin
                    ram_we = 1'b1;
                    finish = 1'b1;
                end
            end

            ST_DN_RDR:
            begin
                if (rd_entry.key < cur_reg.key)
                begin
                    best_next     = rd_entry;
                    best_idx_next = l_idx;
                    moved_next    = 1'b1;
                end
                else
                begin
                    best_next     = cur_reg;
                    best_idx_next = pos_reg;
                    moved_next    = 1'b0;
                end
                ram_raddr  = r_idx;
                state_next = ST_DN_CMP;
            end

            // Right child replaces the running best only if strictly smaller.
            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (r_idx < count_x && rd_entry.key < best_reg.key)
                begin
                    ram_wdata  = rd_entry;
                    pos_next   = r_idx;
                    state_next = ST_DN_RDL;
                end
                else if (moved_reg)
                begin
                    ram_wdata  = best_reg;
                    pos_next   = best_idx_reg;
                    state_next = ST_DN_RDL;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next            = ST_IDLE;
            done_next             = 1'b1;
            result_next.status    = fin_status;
            result_next.remaining = count_next;
            result_next.popped_id = popped_next;
            if (fin_status != STAT_OK)
            begin
                result_next.popped_id = '0;
            end
        end
    end

endmodule

// File: rtl/imh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/tb_indexed_min_heap.sv
// Self-checking testbench for the indexed min-heap: directed and random commands.
module tb_indexed_min_heap;
    import imh_pkg::*;

    localparam int HEAP_DEPTH = 256;
    localparam logic [KEY_BITS-1:0] KEY_INF = '1;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    req_t             req       = '0;
    logic             done;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    indexed_min_heap #(.MAX_NODES(HEAP_DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // heap mirror
    logic [ID_W-1:0]     heap_id  [HEAP_DEPTH];
    logic [KEY_BITS-1:0] heap_key [HEAP_DEPTH];
    int unsigned         heap_len;
    logic [CNT_W-1:0]    load_count;

    result_t pending_results[$];
    int      idle_pct;
    int      mismatches;
    int      cmds_sent;
    int      cmd_tally[4];
    int      empty_reports;
    int      missing_reports;
    int      cfg_writes;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [ID_W-1:0]     ti;
        logic [KEY_BITS-1:0] tk;
        ti = heap_id[a];
        tk = heap_key[a];
        heap_id[a]  = heap_id[b];
        heap_key[a] = heap_key[b];
        heap_id[b]  = ti;
        heap_key[b] = tk;
    endfunction

    // to_root: delete drags the entry all the way up regardless of keys
    function automatic void sift_toward_root(int unsigned pos, bit to_root);
        int unsigned up;
        while (pos != 0) begin
            up = (pos - 1) / 2;
            if (!to_root && !(heap_key[up] > heap_key[pos]))
                break;
            swap_slots(pos, up);
            pos = up;
        end
    endfunction

    function automatic void sift_toward_leaves(int unsigned pos);
        int unsigned lc;
        int unsigned rc;
        int unsigned best;
        forever begin
            lc   = 2 * pos + 1;
            rc   = lc + 1;
            best = pos;
            if (lc < heap_len && heap_key[lc] < heap_key[best])
                best = lc;
            if (rc < heap_len && heap_key[rc] < heap_key[best])
                best = rc;
            if (best == pos)
                break;
            swap_slots(pos, best);
            pos = best;
        end
    endfunction

    function automatic int unsigned slot_of(logic [NODE_W-1:0] id);
        for (int unsigned i = 0; i < heap_len; i++)
            if (heap_id[i] == ID_W'(id))
                return i;
        return heap_len;
    endfunction

    function automatic logic [NODE_W-1:0] take_root();
        logic [NODE_W-1:0] id;
        id = heap_id[0][NODE_W-1:0];
        heap_len--;
        if (heap_len > 0) begin
            heap_id[0]  = heap_id[heap_len];
            heap_key[0] = heap_key[heap_len];
            sift_toward_leaves(0);
        end
        return id;
    endfunction

    function automatic result_t predict_heap(req_t r);
        result_t     res;
        int unsigned pos;
        int unsigned n;
        res        = '0;
        res.status = STAT_OK;
        case (r.cmd)
            CMD_INIT: begin
                n = (load_count > HEAP_DEPTH) ? HEAP_DEPTH : load_count;
                for (int unsigned i = 0; i < n; i++) begin
                    heap_id[i]  = ID_W'(i);
                    heap_key[i] = KEY_INF;
                end
                heap_len = n;
            end
            CMD_DECREASE: begin
                pos = slot_of(r.node_id);
                if (pos >= heap_len)
                    res.status = STAT_MISSING;
                else if (r.new_key < heap_key[pos]) begin
                    heap_key[pos] = r.new_key;
                    sift_toward_root(pos, 1'b0);
                end
            end
            CMD_POP: begin
                if (heap_len == 0)
                    res.status = STAT_EMPTY;
                else
                    res.popped_id = take_root();
            end
            default: begin
                if (heap_len == 0)
                    res.status = STAT_EMPTY;
                else begin
                    pos = slot_of(r.node_id);
                    if (pos >= heap_len)
                        res.status = STAT_MISSING;
                    else begin
                        sift_toward_root(pos, 1'b1);
                        res.popped_id = take_root();
                    end
                end
            end
        endcase
        res.remaining = CNT_W'(heap_len);
        return res;
    endfunction

    function automatic void note_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0t %s: want id=%0d st=%s rem=%0d, got id=%0d st=%0d rem=%0d",
                     $realtime, what, want.popped_id, want.status.name(), want.remaining,
                     got.popped_id, got.status, got.remaining);
    endfunction

    // result checker: the receiver cannot stall, so every done beat is taken
    always @(posedge clk) begin
        result_t want;
        if (rst_n && done === 1'b1) begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result", '0, result);
            else begin
                want = pending_results.pop_front();
                if (result.popped_id !== want.popped_id)
                    note_mismatch("popped_id", want, result);
                else if (result.status !== want.status)
                    note_mismatch("status", want, result);
                else if (result.remaining !== want.remaining)
                    note_mismatch("remaining", want, result);
            end
        end
    end

    task automatic send_cmd(input cmd_t c, input logic [NODE_W-1:0] id,
                            input logic [KEY_BITS-1:0] key);
        req_t    r;
        result_t want;
        r.cmd     = c;
        r.node_id = id;
        r.new_key = key;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy !== 1'b0);
        want = predict_heap(r);
        pending_results.push_back(want);
        cmds_sent++;
        cmd_tally[c]++;
        if (want.status == STAT_EMPTY)
            empty_reports++;
        if (want.status == STAT_MISSING)
            missing_reports++;
    endtask

    // drops start so the block goes idle, then waits for every result
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        load_count = v;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [NODE_W-1:0] pick_id();
        if (heap_len > 0 && $urandom_range(99) < 75)
            return heap_id[$urandom_range(heap_len - 1)][NODE_W-1:0];
        return NODE_W'($urandom_range(255));
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key(logic [NODE_W-1:0] id);
        int unsigned pos;
        int          sel;
        sel = $urandom_range(99);
        pos = slot_of(id);
        if (sel < 20 && pos < heap_len)
            return heap_key[pos];               // equal: no change
        if (sel < 30 && pos < heap_len && heap_key[pos] != 0)
            return heap_key[pos] - KEY_BITS'($urandom_range(1, 3));
        if (sel < 55)
            return KEY_BITS'($urandom_range(15)); // narrow range, many ties
        if (sel < 62)
            return KEY_INF;
        if (sel < 67)
            return '0;
        return KEY_BITS'($urandom);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return CNT_W'($urandom_range(1, 12));
        if (sel < 85) return CNT_W'($urandom_range(13, 64));
        if (sel < 89) return CNT_W'($urandom_range(129, 255));
        if (sel < 94) return CNT_W'(HEAP_DEPTH);
        if (sel < 97) return '0;
        return CNT_W'($urandom_range(257, 511));
    endfunction

    task automatic send_random_op();
        logic [NODE_W-1:0] id;
        int                sel;
        sel = $urandom_range(99);
        id  = pick_id();
        if (sel < 45)
            send_cmd(CMD_DECREASE, id, pick_key(id));
        else if (sel < 70)
            send_cmd(CMD_POP, NODE_W'($urandom), KEY_BITS'($urandom));
        else if (sel < 90)
            send_cmd(CMD_DELETE, id, KEY_BITS'($urandom));
        else if (sel < 95)
            send_cmd(CMD_INIT, NODE_W'($urandom), KEY_BITS'($urandom));
        else
            send_cmd(cmd_t'($urandom_range(3)), NODE_W'($urandom), KEY_BITS'($urandom));
    endtask

    task automatic test_empty_heap();
        idle_pct = 0;
        send_cmd(CMD_DECREASE, 8'd0, '0);
        send_cmd(CMD_POP, 8'd0, '0);
        send_cmd(CMD_DELETE, 8'd255, KEY_INF);
    endtask

    task automatic test_init_extremes();
        write_node_count('0);
        send_cmd(CMD_INIT, 8'd0, '0);
        send_cmd(CMD_POP, 8'd0, '0);
        write_node_count('1);                   // above depth, saturates
        send_cmd(CMD_INIT, 8'd255, KEY_INF);
    endtask

    task automatic test_key_updates();
        send_cmd(CMD_DECREASE, 8'd255, '0);
        send_cmd(CMD_DECREASE, 8'd0, '0);       // tie with the root
        send_cmd(CMD_DECREASE, 8'd255, 32'd9);  // larger: ignored
        send_cmd(CMD_DECREASE, 8'd7, KEY_INF);  // equal: ignored
        send_cmd(CMD_DECREASE, 8'd128, 32'd1);
        send_cmd(CMD_DECREASE, 8'd200, KEY_INF - 1);
        send_cmd(CMD_POP, 8'd0, '0);
        send_cmd(CMD_DELETE, 8'd128, '0);
        send_cmd(CMD_DELETE, 8'd128, '0);       // already gone
        send_cmd(CMD_DELETE, 8'd200, '0);
        send_cmd(CMD_POP, 8'd0, '0);
    endtask

    task automatic test_single_and_pair();
        write_node_count(CNT_W'(1));
        send_cmd(CMD_INIT, 8'd0, '0);
        send_cmd(CMD_POP, 8'd0, '0);
        send_cmd(CMD_POP, 8'd0, '0);
        write_node_count(CNT_W'(2));
        send_cmd(CMD_INIT, 8'd0, '0);
        send_cmd(CMD_DELETE, 8'd1, '0);
        send_cmd(CMD_DECREASE, 8'd1, '0);       // absent
    endtask

    // burst at full rate, then hold the sender until the heap has answered
    task automatic test_drain_pause();
        idle_pct = 0;
        write_node_count(CNT_W'(8));
        send_cmd(CMD_INIT, 8'd0, '0);
        repeat (10) send_random_op();
        drain_results();
        @(posedge clk);
        repeat (4) send_random_op();
    endtask

    task automatic test_random_searches(input int pct, input int quota);
        int n;
        int ops;
        idle_pct = pct;
        n = 0;
        while (n < quota) begin
            if ($urandom_range(2) == 0)
                write_node_count(pick_count());
            send_cmd(CMD_INIT, NODE_W'($urandom), KEY_BITS'($urandom));
            ops = $urandom_range(5, 40);
            repeat (ops) send_random_op();
            n += ops + 1;
        end
    endtask

    initial begin
        heap_len        = 0;
        load_count      = CNT_W'(HEAP_DEPTH);
        idle_pct        = 0;
        mismatches      = 0;
        cmds_sent       = 0;
        empty_reports   = 0;
        missing_reports = 0;
        cfg_writes      = 0;
        cmd_tally       = '{default: 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_heap();
        test_init_extremes();
        test_key_updates();
        test_single_and_pair();
        test_drain_pause();
        test_random_searches(0, 225);
        test_random_searches(86, 225);
        test_random_searches(13, 225);
        test_random_searches(0, 225);

        drain_results();
        repeat (320) @(posedge clk);

        $display("Ran %0d commands (init %0d, decrease %0d, pop %0d, delete %0d), %0d count writes",
                 cmds_sent, cmd_tally[CMD_INIT], cmd_tally[CMD_DECREASE], cmd_tally[CMD_POP],
                 cmd_tally[CMD_DELETE], cfg_writes);
        $display("Empty-heap reports: %0d, missing-node reports: %0d",
                 empty_reports, missing_reports);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
